// ===== rtl/qrsb_pkg.sv =====
// shared types and constants of the queued rgb status blinker
package qrsb_pkg;

  // pending queue geometry
  localparam int DEPTH = 8;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // brightness ceiling in percent
  localparam int MAX_BRI = 100;

  // divide by 100 as multiply by reciprocal, exact for products below 25600
  localparam int PROD_W    = 15;
  localparam int DIV_SHIFT = 22;
  localparam int DIV_RECIP = (1 << DIV_SHIFT) / 100 + 1;
  localparam int MUL_W     = 31;

  // configuration reset value
  localparam logic [15:0] MIN_WAIT_RESET = 16'd100;

  // operation codes of an input word
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_POST = 1'b1;

  // post result codes
  localparam logic [1:0] CODE_OK      = 2'd0;
  localparam logic [1:0] CODE_INVALID = 2'd1;
  localparam logic [1:0] CODE_FULL    = 2'd2;

  // one status as held in the queue and in the front and background slots
  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [6:0]  brightness;
    logic [15:0] duration;
    logic        loop_en;
  } entry_t;

  // queue memory access from the engine
  typedef struct packed {
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    entry_t           wr_data;
    logic [PTR_W-1:0] rd_addr;
  } store_req_t;

  // channel times brightness, before the divide by 100
  typedef struct packed {
    logic [PROD_W-1:0] red;
    logic [PROD_W-1:0] green;
    logic [PROD_W-1:0] blue;
  } prod_t;

  // word passed from the engine to the output stage
  typedef struct packed {
    prod_t      prod;
    logic [1:0] code;
  } token_t;

endpackage

// ===== rtl/qrsb_store.sv =====
// pending status memory with registered read and write forwarding
module qrsb_store (
  input  logic                clk,
  input  qrsb_pkg::store_req_t req,
  output qrsb_pkg::entry_t    rd_data
);

  qrsb_pkg::entry_t mem [qrsb_pkg::DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // read port, a write to the same entry is passed straight through
  always_ff @(posedge clk) begin
    if (req.wr_en && (req.wr_addr == req.rd_addr)) begin
      rd_data <= req.wr_data;
    end else begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// ===== rtl/qrsb_engine.sv =====
// queue pointers, front and background status, blink step and level products
module qrsb_engine (
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [15:0]          min_wait_ms,
  // input words
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 operation,
  input  logic [7:0]           in_red,
  input  logic [7:0]           in_green,
  input  logic [7:0]           in_blue,
  input  logic [7:0]           in_brightness,
  input  logic [15:0]          in_duration_ms,
  input  logic                 in_repeat,
  // queue memory
  output qrsb_pkg::store_req_t store_req,
  input  qrsb_pkg::entry_t     head_data,
  // words to the output stage
  output logic                 tok_valid,
  input  logic                 tok_ready,
  output qrsb_pkg::token_t     tok
);

  logic [qrsb_pkg::PTR_W-1:0] head, head_next, head_inc, tail;
  logic [qrsb_pkg::PTR_W:0]   tail_sum;
  logic [qrsb_pkg::CNT_W-1:0] count, count_next;
  qrsb_pkg::entry_t           front, front_next, back, back_next, post_entry, cur, src;
  qrsb_pkg::prod_t            prod, prod_next;
  logic                       phase, phase_next, phase_base;
  logic [15:0]                wait_cnt, wait_cnt_next, wait_len;
  logic [16:0]                wait_inc;
  logic [15:0]                min_wait;
  logic [1:0]                 code;
  logic                       accept, is_post, is_pop, do_step, full, invalid;
  logic                       show_off, write_ok;

  assign accept    = in_valid && in_ready;
  assign in_ready  = !tok_valid || tok_ready;
  assign cfg_ready = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_wait <= qrsb_pkg::MIN_WAIT_RESET;
    end else if (cfg_valid) begin
      min_wait <= min_wait_ms;
    end
  end

  // request checks and queue addressing
  always_comb begin
    post_entry.red        = in_red;
    post_entry.green      = in_green;
    post_entry.blue       = in_blue;
    post_entry.brightness = (in_brightness > 8'(qrsb_pkg::MAX_BRI)) ?
                            7'(qrsb_pkg::MAX_BRI) : in_brightness[6:0];
    post_entry.duration   = in_duration_ms;
    post_entry.loop_en    = in_repeat;
    is_post  = (operation == qrsb_pkg::OP_POST);
    invalid  = (in_duration_ms == 16'd0) && !in_repeat;
    full     = (count == qrsb_pkg::CNT_W'(qrsb_pkg::DEPTH));
    write_ok = accept && is_post && !invalid && !full;
    is_pop   = !is_post && (count != '0);
    tail_sum = (qrsb_pkg::PTR_W+1)'(head) + (qrsb_pkg::PTR_W+1)'(count);
    tail     = (tail_sum >= (qrsb_pkg::PTR_W+1)'(qrsb_pkg::DEPTH)) ?
               qrsb_pkg::PTR_W'(tail_sum - (qrsb_pkg::PTR_W+1)'(qrsb_pkg::DEPTH)) :
               qrsb_pkg::PTR_W'(tail_sum);
    head_inc = (head == qrsb_pkg::PTR_W'(qrsb_pkg::DEPTH - 1)) ?
               '0 : head + qrsb_pkg::PTR_W'(1);
    if (!is_post) begin
      code = qrsb_pkg::CODE_OK;
    end else if (invalid) begin
      code = qrsb_pkg::CODE_INVALID;
    end else if (full) begin
      code = qrsb_pkg::CODE_FULL;
    end else begin
      code = qrsb_pkg::CODE_OK;
    end
  end

  // pointer and count update
  always_comb begin
    head_next  = head;
    count_next = count;
    if (accept && is_pop) begin
      head_next  = head_inc;
      count_next = count - qrsb_pkg::CNT_W'(1);
    end else if (write_ok) begin
      count_next = count + qrsb_pkg::CNT_W'(1);
    end
  end

  // memory requests, the next head entry is read ahead into the store's read register
  always_comb begin
    store_req.wr_en   = write_ok;
    store_req.wr_addr = tail;
    store_req.wr_data = post_entry;
    store_req.rd_addr = head_next;
  end

  // tick handling: pop, timeout step or wait count
  always_comb begin
    cur        = is_pop ? head_data : front;
    phase_base = is_pop ? 1'b0 : phase;
    back_next  = (is_pop && head_data.loop_en) ? head_data : back;
    wait_len   = (front.duration >= min_wait) ? front.duration : min_wait;
    wait_inc   = {1'b0, wait_cnt} + 17'd1;
    do_step    = is_pop || (wait_inc >= {1'b0, wait_len});
    front_next = cur;
    phase_next = !phase_base;
    src        = cur;
    show_off   = 1'b0;
    if (!phase_base || (cur.duration == 16'd0)) begin
      src = cur;
    end else if (cur.loop_en) begin
      show_off = 1'b1;
    end else begin
      src        = back_next;
      phase_next = 1'b1;
      front_next = back_next;
    end
    wait_cnt_next = do_step ? 16'd0 : wait_inc[15:0];
  end

  // level products of the status being shown
  always_comb begin
    if (show_off) begin
      prod_next = '0;
    end else begin
      prod_next.red   = qrsb_pkg::PROD_W'(src.red)   * qrsb_pkg::PROD_W'(src.brightness);
      prod_next.green = qrsb_pkg::PROD_W'(src.green) * qrsb_pkg::PROD_W'(src.brightness);
      prod_next.blue  = qrsb_pkg::PROD_W'(src.blue)  * qrsb_pkg::PROD_W'(src.brightness);
    end
  end

  // blinker state
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= '0;
      front    <= '0;
      back     <= '0;
      phase    <= 1'b0;
      wait_cnt <= '0;
      prod     <= '0;
    end else if (accept) begin
      head  <= head_next;
      count <= count_next;
      if (!is_post) begin
        back     <= back_next;
        wait_cnt <= wait_cnt_next;
        if (do_step) begin
          front <= front_next;
          phase <= phase_next;
          prod  <= prod_next;
        end else if (is_pop) begin
          front <= cur;
        end
      end
    end
  end

  // word register towards the output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else if (in_ready) begin
      tok_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tok.code <= code;
      tok.prod <= (!is_post && do_step) ? prod_next : prod;
    end
  end

  // the queue never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= qrsb_pkg::CNT_W'(qrsb_pkg::DEPTH))
    else $error("pending count above depth");

  // a refused post leaves the queue alone
  a_refused_post: assert property (@(posedge clk) disable iff (rst)
    (accept && is_post && (code != qrsb_pkg::CODE_OK)) |=> $stable(count) && $stable(head))
    else $error("refused post changed the queue");

  // a pop always shows the new front and restarts the wait
  a_pop_step: assert property (@(posedge clk) disable iff (rst)
    (accept && is_pop) |=> phase && (wait_cnt == 16'd0))
    else $error("pop did not step");

endmodule

// ===== rtl/qrsb_scale.sv =====
// divide-by-100 of the level products and the output register
module qrsb_scale (
  input  logic             clk,
  input  logic             rst,
  input  logic             tok_valid,
  output logic             tok_ready,
  input  qrsb_pkg::token_t tok,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       red_level,
  output logic [7:0]       green_level,
  output logic [7:0]       blue_level,
  output logic [1:0]       post_code
);

  logic [qrsb_pkg::MUL_W-1:0] mul_red, mul_green, mul_blue;

  assign tok_ready = !out_valid || out_ready;

  // reciprocal multiplies
  always_comb begin
    mul_red   = qrsb_pkg::MUL_W'(tok.prod.red)   * qrsb_pkg::MUL_W'(qrsb_pkg::DIV_RECIP);
    mul_green = qrsb_pkg::MUL_W'(tok.prod.green) * qrsb_pkg::MUL_W'(qrsb_pkg::DIV_RECIP);
    mul_blue  = qrsb_pkg::MUL_W'(tok.prod.blue)  * qrsb_pkg::MUL_W'(qrsb_pkg::DIV_RECIP);
  end

  // output word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tok_ready) begin
      out_valid <= tok_valid;
    end
  end

  // output word payload
  always_ff @(posedge clk) begin
    if (tok_valid && tok_ready) begin
      red_level   <= mul_red[qrsb_pkg::DIV_SHIFT +: 8];
      green_level <= mul_green[qrsb_pkg::DIV_SHIFT +: 8];
      blue_level  <= mul_blue[qrsb_pkg::DIV_SHIFT +: 8];
      post_code   <= tok.code;
    end
  end

endmodule

// ===== rtl/queued_rgb_status_blinker_core.sv =====
// Status LED blinker: posts queue colour requests, ticks pop them or time the
// blink. One input word is taken every cycle while the output side is not
// stalled; its result word passes the engine word register, then the
// divide-by-100 output register. The queue memory reads the next head entry
// ahead into its read register, with write forwarding, so a pop never
// waits on the memory. Configuration writes to min_wait_ms are taken at once
// and must be made while the block is idle.
module queued_rgb_status_blinker_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] min_wait_ms,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_brightness,
  input  logic [15:0] in_duration_ms,
  input  logic        in_repeat,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  red_level,
  output logic [7:0]  green_level,
  output logic [7:0]  blue_level,
  output logic [1:0]  post_code
);

  qrsb_pkg::store_req_t store_req;
  qrsb_pkg::entry_t     head_data;
  qrsb_pkg::token_t     tok;
  logic                 tok_valid, tok_ready;

  // pending queue memory
  qrsb_store u_store (
    .clk     (clk),
    .req     (store_req),
    .rd_data (head_data)
  );

  // queue control and blink state
  qrsb_engine u_engine (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .min_wait_ms    (min_wait_ms),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_brightness  (in_brightness),
    .in_duration_ms (in_duration_ms),
    .in_repeat      (in_repeat),
    .store_req      (store_req),
    .head_data      (head_data),
    .tok_valid      (tok_valid),
    .tok_ready      (tok_ready),
    .tok            (tok)
  );

  // level scaling and output register
  qrsb_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .tok_valid   (tok_valid),
    .tok_ready   (tok_ready),
    .tok         (tok),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .red_level   (red_level),
    .green_level (green_level),
    .blue_level  (blue_level),
    .post_code   (post_code)
  );

endmodule

// ===== sim/tb_queued_rgb_status_blinker_core.sv =====
// testbench for the queued rgb status blinker core: directed table, then random words
`timescale 1ns / 100ps

module tb_queued_rgb_status_blinker_core;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_WORDS = 150;
  localparam int N_PHASES    = 6;

  // one request word as driven on the input channel
  typedef struct packed {
    logic        op;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  bri;
    logic [15:0] dur;
    logic        rpt;
  } led_req_t;

  // one result word as seen on the output channel
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] code;
  } led_word_t;

  // a status held in the pending queue, front or background slot
  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [6:0]  bri;
    logic [15:0] dur;
    logic        lp;
  } led_status_t;

  // directed row: a word, and the result typed in where it is obvious
  typedef struct {
    led_req_t  req;
    bit        typed;
    led_word_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] min_wait_ms;
  logic        in_valid;
  logic        in_ready;
  logic        operation;
  logic [7:0]  in_red;
  logic [7:0]  in_green;
  logic [7:0]  in_blue;
  logic [7:0]  in_brightness;
  logic [15:0] in_duration_ms;
  logic        in_repeat;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  red_level;
  logic [7:0]  green_level;
  logic [7:0]  blue_level;
  logic [1:0]  post_code;

  // blinker state mirrored by the predictor
  led_status_t queue_mem [qrsb_pkg::DEPTH];
  int          q_head = 0;
  int          q_count = 0;
  led_status_t front_st = '0;
  led_status_t back_st = '0;
  bit          blink_on = 1'b0;
  logic [15:0] wait_cnt = '0;
  logic [7:0]  lvl_r = '0;
  logic [7:0]  lvl_g = '0;
  logic [7:0]  lvl_b = '0;
  logic [15:0] min_wait_cfg = qrsb_pkg::MIN_WAIT_RESET;

  led_word_t   levels_due [$];
  dir_row_t    dir_rows [$];
  int          mismatch_count = 0;
  int          words_sent = 0;
  int          cycle_count = 0;
  int          hold_marks [2] = '{250, 700};
  logic [15:0] phase_waits [N_PHASES] = '{16'd1, 16'd0, 16'd65535, 16'd2, 16'd7, 16'd100};

  queued_rgb_status_blinker_core u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .min_wait_ms    (min_wait_ms),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_brightness  (in_brightness),
    .in_duration_ms (in_duration_ms),
    .in_repeat      (in_repeat),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .red_level      (red_level),
    .green_level    (green_level),
    .blue_level     (blue_level),
    .post_code      (post_code)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // levels are channel times brightness over one hundred
  function automatic void show_status(input led_status_t s);
    lvl_r = 8'((int'(s.red) * int'(s.bri)) / qrsb_pkg::MAX_BRI);
    lvl_g = 8'((int'(s.green) * int'(s.bri)) / qrsb_pkg::MAX_BRI);
    lvl_b = 8'((int'(s.blue) * int'(s.bri)) / qrsb_pkg::MAX_BRI);
  endfunction

  // one blink update after a pop or a timeout
  function automatic void step_blink();
    blink_on = !blink_on;
    if (blink_on || front_st.dur == 16'd0) begin
      show_status(front_st);
    end else if (front_st.lp) begin
      lvl_r = '0;
      lvl_g = '0;
      lvl_b = '0;
    end else begin
      // one-shot over: fall back to the background
      show_status(back_st);
      blink_on = 1'b1;
      front_st = back_st;
    end
    wait_cnt = '0;
  endfunction

  // expected result word of one accepted request, advancing the mirrored state
  function automatic led_word_t predict_word(input led_req_t r);
    led_status_t s;
    int          wait_len;
    led_word_t   w;
    w.code = qrsb_pkg::CODE_OK;
    if (r.op == qrsb_pkg::OP_POST) begin
      s.red   = r.red;
      s.green = r.green;
      s.blue  = r.blue;
      s.bri   = (r.bri > qrsb_pkg::MAX_BRI) ? 7'(qrsb_pkg::MAX_BRI) : r.bri[6:0];
      s.dur   = r.dur;
      s.lp    = r.rpt;
      if (r.dur == 16'd0 && !r.rpt) begin
        w.code = qrsb_pkg::CODE_INVALID;
      end else if (q_count >= qrsb_pkg::DEPTH) begin
        w.code = qrsb_pkg::CODE_FULL;
      end else begin
        queue_mem[(q_head + q_count) % qrsb_pkg::DEPTH] = s;
        q_count++;
      end
    end else if (q_count > 0) begin
      // pop a waiting status
      front_st = queue_mem[q_head];
      q_head = (q_head + 1) % qrsb_pkg::DEPTH;
      q_count--;
      blink_on = 1'b0;
      if (front_st.lp) back_st = front_st;
      step_blink();
    end else begin
      // count the wait, a zero length acts as one
      wait_len = (front_st.dur >= min_wait_cfg) ? int'(front_st.dur) : int'(min_wait_cfg);
      if (int'(wait_cnt) + 1 >= wait_len) step_blink();
      else wait_cnt = wait_cnt + 16'd1;
    end
    w.red   = lvl_r;
    w.green = lvl_g;
    w.blue  = lvl_b;
    return w;
  endfunction

  function automatic void add_row(input logic op, input logic [7:0] r, input logic [7:0] g,
                                  input logic [7:0] b, input logic [7:0] bri,
                                  input logic [15:0] dur, input logic rpt, input bit typed,
                                  input logic [7:0] er, input logic [7:0] eg,
                                  input logic [7:0] eb, input logic [1:0] ec);
    dir_row_t row;
    row.req   = '{op: op, red: r, green: g, blue: b, bri: bri, dur: dur, rpt: rpt};
    row.typed = typed;
    row.want  = '{red: er, green: eg, blue: eb, code: ec};
    dir_rows.push_back(row);
  endfunction

  // random request, mostly short durations so that timeouts come often
  function automatic led_req_t rand_req(input bit post_only);
    led_req_t r;
    int       pick;
    r.op    = (post_only || $urandom_range(0, 99) < 30) ? qrsb_pkg::OP_POST
                                                         : qrsb_pkg::OP_TICK;
    r.red   = 8'($urandom_range(0, 255));
    r.green = 8'($urandom_range(0, 255));
    r.blue  = 8'($urandom_range(0, 255));
    r.bri   = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, 100));
    pick = $urandom_range(0, 99);
    if (pick < 20) r.dur = 16'd0;
    else if (pick < 75) r.dur = 16'($urandom_range(1, 8));
    else if (pick < 90) r.dur = 16'($urandom_range(9, 300));
    else r.dur = 16'($urandom_range(0, 65535));
    r.rpt = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // offer one word, with random gaps, and log its expected result on acceptance
  task automatic send_word(input led_req_t r, input bit typed, input led_word_t typed_word);
    led_word_t w;
    int        idle_pct;
    idle_pct = (words_sent > 450 && words_sent < 580) ? 0 : 35;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    operation      <= r.op;
    in_red         <= r.red;
    in_green       <= r.green;
    in_blue        <= r.blue;
    in_brightness  <= r.bri;
    in_duration_ms <= r.dur;
    in_repeat      <= r.rpt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    w = predict_word(r);
    levels_due.push_back(typed ? typed_word : w);
    words_sent++;
  endtask

  // configuration write, only once every result is back
  task automatic set_min_wait(input logic [15:0] v);
    in_valid <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_valid   <= 1'b1;
    min_wait_ms <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid    <= 1'b0;
    min_wait_cfg = v;
  endtask

  // stimulus
  initial begin
    int        phase;
    int        burst_left;
    led_req_t  req;
    logic [15:0] wait_val;
    rst            <= 1'b1;
    cfg_valid      <= 1'b0;
    min_wait_ms    <= '0;
    in_valid       <= 1'b0;
    operation      <= qrsb_pkg::OP_TICK;
    in_red         <= '0;
    in_green       <= '0;
    in_blue        <= '0;
    in_brightness  <= '0;
    in_duration_ms <= '0;
    in_repeat      <= 1'b0;
    burst_left = 0;

    // tick from reset, invalid post, clamped white, then fill the queue to full
    add_row(qrsb_pkg::OP_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 1'b0, 1,
            8'd0, 8'd0, 8'd0, qrsb_pkg::CODE_OK);
    add_row(qrsb_pkg::OP_POST, 8'd10, 8'd20, 8'd30, 8'd50, 16'd0, 1'b0, 1,
            8'd0, 8'd0, 8'd0, qrsb_pkg::CODE_INVALID);
    add_row(qrsb_pkg::OP_POST, 8'd255, 8'd255, 8'd255, 8'd255, 16'd3, 1'b1, 1,
            8'd0, 8'd0, 8'd0, qrsb_pkg::CODE_OK);
    add_row(qrsb_pkg::OP_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 1'b0, 1,
            8'd255, 8'd255, 8'd255, qrsb_pkg::CODE_OK);
    add_row(qrsb_pkg::OP_POST, 8'd0, 8'd0, 8'd0, 8'd0, 16'd1, 1'b0, 0,
            '0, '0, '0, qrsb_pkg::CODE_OK);
    add_row(qrsb_pkg::OP_POST, 8'd255, 8'd0, 8'd0, 8'd100, 16'd65535, 1'b0, 0,
            '0, '0, '0, qrsb_pkg::CODE_OK);
    add_row(qrsb_pkg::OP_POST, 8'd0, 8'd255, 8'd0, 8'd101, 16'd0, 1'b1, 0,
            '0, '0, '0, qrsb_pkg::CODE_OK);
    add_row(qrsb_pkg::OP_POST, 8'd0, 8'd0, 8'd255, 8'd1, 16'd2, 1'b1, 0,
            '0, '0, '0, qrsb_pkg::CODE_OK);
    add_row(qrsb_pkg::OP_POST, 8'd128, 8'd64, 8'd32, 8'd99, 16'd5, 1'b0, 0,
            '0, '0, '0, qrsb_pkg::CODE_OK);
    add_row(qrsb_pkg::OP_POST, 8'd1, 8'd1, 8'd1, 8'd100, 16'd1, 1'b1, 0,
            '0, '0, '0, qrsb_pkg::CODE_OK);
    add_row(qrsb_pkg::OP_POST, 8'd200, 8'd150, 8'd100, 8'd60, 16'd4, 1'b0, 0,
            '0, '0, '0, qrsb_pkg::CODE_OK);
    add_row(qrsb_pkg::OP_POST, 8'd255, 8'd255, 8'd255, 8'd100, 16'd2, 1'b1, 0,
            '0, '0, '0, qrsb_pkg::CODE_OK);
    add_row(qrsb_pkg::OP_POST, 8'd9, 8'd9, 8'd9, 8'd50, 16'd7, 1'b1, 1,
            8'd255, 8'd255, 8'd255, qrsb_pkg::CODE_FULL);
    repeat (11) add_row(qrsb_pkg::OP_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 1'b0, 0,
                        '0, '0, '0, qrsb_pkg::CODE_OK);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (dir_rows[i]) send_word(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

    // random phases, each under its own minimum wait
    for (phase = 0; phase < N_PHASES; phase++) begin
      wait_val = (phase == N_PHASES - 1) ? 16'($urandom_range(3, 40)) : phase_waits[phase];
      set_min_wait(wait_val);
      repeat (PHASE_WORDS) begin
        if (burst_left > 0) begin
          req = rand_req(1'b1);
          burst_left--;
        end else begin
          if ($urandom_range(0, 39) == 0) burst_left = $urandom_range(8, 12);
          req = rand_req(1'b0);
        end
        send_word(req, 1'b0, '0);
      end
    end

    // drain
    in_valid <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // result side: check each word, random stalls and two long hold-offs
  initial begin
    int        hold_cycles;
    int        mark_idx;
    int        idle_pct;
    led_word_t got;
    led_word_t want;
    hold_cycles = 0;
    mark_idx = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got = {red_level, green_level, blue_level, post_code};
        if (levels_due.size() == 0) begin
          $display("%0t: result word with none expected: %0d %0d %0d code %0d",
                   $time, got.red, got.green, got.blue, got.code);
          mismatch_count++;
        end else begin
          want = levels_due.pop_front();
          if (got.red !== want.red) begin
            $display("%0t: red_level expected %0d got %0d", $time, want.red, got.red);
            mismatch_count++;
          end
          if (got.green !== want.green) begin
            $display("%0t: green_level expected %0d got %0d", $time, want.green, got.green);
            mismatch_count++;
          end
          if (got.blue !== want.blue) begin
            $display("%0t: blue_level expected %0d got %0d", $time, want.blue, got.blue);
            mismatch_count++;
          end
          if (got.code !== want.code) begin
            $display("%0t: post_code expected %0d got %0d", $time, want.code, got.code);
            mismatch_count++;
          end
        end
      end
      if (hold_cycles == 0 && mark_idx < 2 && words_sent >= hold_marks[mark_idx]) begin
        hold_cycles = 80;
        mark_idx++;
      end
      idle_pct = (words_sent > 450 && words_sent < 580) ? 0 : 35;
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= idle_pct);
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

endmodule
